// File: hdl/inverse_distance_weighted_interp_core_macros.svh
// assertion macros shared by the interpolation core
`ifndef INVERSE_DISTANCE_WEIGHTED_INTERP_CORE_MACROS_SVH
`define INVERSE_DISTANCE_WEIGHTED_INTERP_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define IDWI_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define IDWI_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/idwi_pkg.sv
// shared types and constants of the interpolation core
package idwi_pkg;

	localparam int VAL_W    = 24;
	localparam int DIST_W   = 32;
	localparam int IDX_IN_W = 12;
	localparam int ACC_W    = 60;
	localparam int WSUM_W   = 36;
	localparam int PROD_W   = 57;
	localparam int DVD_W    = 60;
	localparam int DVS_W    = 36;
	localparam int STEP_W   = 6;
	localparam int QDEPTH   = 2;

	localparam logic REQ_WRITE    = 1'b0;
	localparam logic REQ_NEIGHBOR = 1'b1;

	// 2^32 left aligned in the dividend so that 33 steps consume it
	localparam logic [DVD_W-1:0]  RECIP_DVD   = {1'b1, {(DVD_W-1){1'b0}}};
	localparam logic [STEP_W-1:0] RECIP_STEPS = 6'd33;
	localparam logic [STEP_W-1:0] FINAL_STEPS = 6'd60;

	localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};
	localparam logic [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [VAL_W-1:0] OUT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] OUT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		logic              kind;
		logic [VAL_W-1:0]  value;
		logic [DIST_W-1:0] dst;
		logic              last;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quot;
	} div_rsp_t;

endpackage

// File: hdl/idwi_ram.sv
// generic single write port ram with registered read
module idwi_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/idwi_front.sv
// request intake: index reduction, distance clamp and a short request queue
module idwi_front import idwi_pkg::*; #(
	parameter int NODE_COUNT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          req_type,
	input  logic [IDX_IN_W-1:0]           node_index,
	input  logic [VAL_W-1:0]              field_value,
	input  logic [DIST_W-1:0]             distance,
	input  logic                          last_neighbor,
	output logic                          busy,
	output logic                          q_valid,
	output item_t                         q_item,
	output logic [$clog2(NODE_COUNT)-1:0] q_idx,
	input  logic                          q_pop
);

	localparam int AW    = $clog2(NODE_COUNT);
	localparam int MW    = (AW > IDX_IN_W) ? AW : IDX_IN_W;
	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	logic [MW-1:0]    red;
	logic [AW-1:0]    idx;
	item_t            item;
	logic             push;
	item_t            item_q [QDEPTH];
	logic [AW-1:0]    idx_q  [QDEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;

	// restoring reduction modulo the table size, dead steps fold away
	always_comb begin
		red = MW'(node_index);
		for (int k = MW - 1; k >= 0; k--) begin
			if (longint'(red) >= (longint'(NODE_COUNT) << k)) begin
				red = red - MW'(longint'(NODE_COUNT) << k);
			end
		end
	end

	assign idx = red[AW-1:0];

	always_comb begin
		item.kind  = req_type;
		item.value = field_value;
		item.dst   = (distance == '0) ? DIST_W'(1) : distance;
		item.last  = last_neighbor;
	end

	assign busy    = (cnt_q == CNT_W'(QDEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_item  = item_q[rp_q];
	assign q_idx   = idx_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wp_q] <= item;
			idx_q[wp_q]  <= idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PTR_W'(1);
			end
			if (q_pop) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/idwi_div.sv
// radix-2 restoring divider, one quotient bit per cycle while busy
module idwi_div import idwi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quot_q <= {quot_q[DVD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// File: hdl/idwi_back.sv
// execution side: node table, weight, accumulation and final quotient
module idwi_back import idwi_pkg::*; #(
	parameter int NODE_COUNT    = 4096,
	parameter int MAX_NEIGHBORS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  item_t                         q_item,
	input  logic [$clog2(NODE_COUNT)-1:0] q_idx,
	output logic                          q_pop,
	output div_req_t                      div_req,
	input  div_rsp_t                      div_rsp,
	output logic                          done,
	output logic [VAL_W-1:0]              interpolated_value
);

	localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RECIP = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_ACC   = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_FINAL = 3'd5;

	logic [2:0]               state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     last_q;
	logic                     neg_q;
	logic [DIST_W-1:0]        weight_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]         acc_q;
	logic [WSUM_W-1:0]        wsum_q;
	logic                     done_q;
	logic [VAL_W-1:0]         result_q;

	logic                     ram_we;
	logic                     ram_re;
	logic [VAL_W-1:0]         ram_rdata;
	logic                     take_nbr;
	logic signed [PROD_W-1:0] prod_full;
	logic [ACC_W:0]           acc_ext;
	logic [ACC_W-1:0]         acc_sat;
	logic [WSUM_W:0]          wsum_ext;
	logic [WSUM_W-1:0]        wsum_sat;
	logic [ACC_W-1:0]         acc_mag;
	logic [VAL_W-1:0]         clamped;

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign ram_we   = q_pop && (q_item.kind == REQ_WRITE);
	assign ram_re   = q_pop && (q_item.kind == REQ_NEIGHBOR);
	assign take_nbr = ram_re && (cnt_q < CNT_W'(MAX_NEIGHBORS));

	idwi_ram #(
		.WIDTH(VAL_W),
		.DEPTH(NODE_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_idx),
		.wdata(q_item.value),
		.re   (ram_re),
		.raddr(q_idx),
		.rdata(ram_rdata)
	);

	assign acc_mag = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = RECIP_DVD;
		div_req.divisor  = DVS_W'(q_item.dst);
		div_req.steps    = RECIP_STEPS;
		if (state_q == S_CHECK) begin
			div_req.start    = last_q && (wsum_q != '0);
			div_req.dividend = acc_mag;
			div_req.divisor  = wsum_q;
			div_req.steps    = FINAL_STEPS;
		end else begin
			div_req.start = take_nbr;
		end
	end

	// value times weight, weight taken as a positive signed operand
	assign prod_full = $signed(ram_rdata) * $signed({1'b0, weight_q});

	assign acc_ext  = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(prod_q);
	assign wsum_ext = {1'b0, wsum_q} + (WSUM_W+1)'(weight_q);

	always_comb begin
		if (acc_ext[ACC_W] != acc_ext[ACC_W-1]) begin
			acc_sat = acc_ext[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = acc_ext[ACC_W-1:0];
		end
		wsum_sat = wsum_ext[WSUM_W] ? WSUM_MAX : wsum_ext[WSUM_W-1:0];
	end

	// quotient magnitude back to a signed value clamped to the field range
	always_comb begin
		if (neg_q) begin
			if (div_rsp.quot > {{(DVD_W-VAL_W){1'b0}}, OUT_MIN}) begin
				clamped = OUT_MIN;
			end else begin
				clamped = ~div_rsp.quot[VAL_W-1:0] + VAL_W'(1);
			end
		end else begin
			if (div_rsp.quot > {{(DVD_W-VAL_W){1'b0}}, OUT_MAX}) begin
				clamped = OUT_MAX;
			end else begin
				clamped = div_rsp.quot[VAL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_q <= prod_full;
		end
		if (state_q == S_RECIP && div_rsp.done) begin
			weight_q <= div_rsp.quot[DIST_W] ? {DIST_W{1'b1}} : div_rsp.quot[DIST_W-1:0];
		end
		if (ram_re) begin
			last_q <= q_item.last;
		end
		if (state_q == S_CHECK) begin
			neg_q <= acc_q[ACC_W-1];
		end
		if (state_q == S_CHECK && last_q && wsum_q == '0) begin
			result_q <= '0;
		end else if (state_q == S_FINAL && div_rsp.done) begin
			result_q <= clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			acc_q   <= '0;
			wsum_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take_nbr) begin
						state_q <= S_RECIP;
					end else if (ram_re) begin
						state_q <= S_CHECK;
					end
				end
				S_RECIP: begin
					if (div_rsp.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q   <= acc_sat;
					wsum_q  <= wsum_sat;
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (wsum_q == '0) begin
						done_q  <= 1'b1;
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (div_rsp.done) begin
						done_q  <= 1'b1;
						acc_q   <= '0;
						wsum_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done               = done_q;
	assign interpolated_value = result_q;

endmodule

// File: hdl/inverse_distance_weighted_interp_core.sv
// top level of the shepard inverse distance weighting core
//
// channel   handshake            payload
// request   start / busy         req_type, node_index, field_value, distance, last_neighbor
// result    done (one cycle)     interpolated_value
//
// a node write is taken by the back end without leaving its idle state
// a neighbour runs a reciprocal in the shared divider, then the multiply, accumulate and check states
// the last neighbour of a query adds the final division, skipped when the weight sum is zero
// busy rises when the two-entry request queue is full; results cannot be held off
// no clearing pass after reset: node table entries are undefined until written
`include "inverse_distance_weighted_interp_core_macros.svh"

module inverse_distance_weighted_interp_core import idwi_pkg::*; #(
	parameter int NODE_COUNT    = 4096,
	parameter int MAX_NEIGHBORS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                req_type,
	input  logic [IDX_IN_W-1:0] node_index,
	input  logic [VAL_W-1:0]    field_value,
	input  logic [DIST_W-1:0]   distance,
	input  logic                last_neighbor,
	output logic                done,
	output logic [VAL_W-1:0]    interpolated_value
);

	logic                          q_valid;
	item_t                         q_item;
	logic [$clog2(NODE_COUNT)-1:0] q_idx;
	logic                          q_pop;
	div_req_t                      div_req;
	div_rsp_t                      div_rsp;

	idwi_front #(
		.NODE_COUNT(NODE_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.node_index   (node_index),
		.field_value  (field_value),
		.distance     (distance),
		.last_neighbor(last_neighbor),
		.busy         (busy),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_idx        (q_idx),
		.q_pop        (q_pop)
	);

	idwi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	idwi_back #(
		.NODE_COUNT   (NODE_COUNT),
		.MAX_NEIGHBORS(MAX_NEIGHBORS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_item            (q_item),
		.q_idx             (q_idx),
		.q_pop             (q_pop),
		.div_req           (div_req),
		.div_rsp           (div_rsp),
		.done              (done),
		.interpolated_value(interpolated_value)
	);

	`IDWI_ASSERT_NOW(a_pop_needs_request, clk, arst_n, q_pop, q_valid, "queue popped while empty")
	`IDWI_ASSERT_NOW(a_div_start_idle, clk, arst_n, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`IDWI_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe held over two cycles")

endmodule
